/* rtl/ttm_pkg.sv */
// ----------------------------------------------------------------------------
// ttm_pkg
// Types and constants shared by the temperature trip threshold monitor.
// ----------------------------------------------------------------------------
package ttm_pkg;

   localparam int TEMP_WIDTH = 16;
   localparam int CSR_IDX_WIDTH = 3;

   typedef logic [TEMP_WIDTH-1:0] temp_type;

   typedef enum logic [1:0] {
      OP_SAMPLE   = 2'd0,
      OP_SET_LOW  = 2'd1,
      OP_SET_HIGH = 2'd2,
      OP_INVALID  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_UNSUPPORTED = 2'd1,
      ST_UNKNOWN_SEL = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_HYSTERESIS   = 3'd0,
      CSR_TEMP_FLOOR   = 3'd1,
      CSR_TEMP_CEILING = 3'd2,
      CSR_LOW_DEFAULT  = 3'd3,
      CSR_POLLING_ON   = 3'd4,
      CSR_CAPABLE      = 3'd5
   } csr_index_type;

   typedef struct packed {
      temp_type hysteresis;
      temp_type temp_floor;
      temp_type temp_ceiling;
      temp_type low_default;
      logic     polling_on;
      logic     threshold_capable;
   } cfg_type;

   typedef struct packed {
      temp_type low_point;
      logic     low_valid;
      temp_type high_point;
      logic     high_valid;
      temp_type low_with_hyst;
   } trip_type;

   typedef struct packed {
      opcode_type opcode;
      temp_type   value;
      logic       value_valid;
   } item_type;

   typedef struct packed {
      logic       crossed;
      temp_type   push_value;
      logic       push_enable;
      status_type status;
   } result_type;

endpackage

/* rtl/ttm_req_if.sv */
// ----------------------------------------------------------------------------
// ttm_req_if
// Request channel: valid/ready handshake carrying one monitor item.
// ----------------------------------------------------------------------------
interface ttm_req_if import ttm_pkg::*; ();
   logic     valid;
   logic     ready;
   logic [1:0] opcode;
   temp_type value;
   logic     value_valid;

   modport source (output valid, opcode, value, value_valid, input ready);
   modport sink   (input valid, opcode, value, value_valid, output ready);
endinterface

/* rtl/ttm_rsp_if.sv */
// ----------------------------------------------------------------------------
// ttm_rsp_if
// Response channel: valid/ready handshake carrying one monitor result.
// ----------------------------------------------------------------------------
interface ttm_rsp_if import ttm_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       crossed;
   temp_type   push_value;
   logic       push_enable;
   logic [1:0] status;

   modport source (output valid, crossed, push_value, push_enable, status, input ready);
   modport sink   (input valid, crossed, push_value, push_enable, status, output ready);
endinterface

/* rtl/temp_trip_threshold_monitor.sv */
// ----------------------------------------------------------------------------
// temp_trip_threshold_monitor
// Items pass the input register, then the result register, from request
// to response transaction. Throughput: one transaction per cycle while the
// response side is ready. The trip state updates as an item leaves the input
// register, so the next item always sees it. Reset (synchronous, active high)
// clears both pipeline valids, the trip points and loads the config defaults.
// ----------------------------------------------------------------------------
module temp_trip_threshold_monitor import ttm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   ttm_req_if.sink                  req_bus,
   ttm_rsp_if.source                rsp_bus,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  temp_type                 csr_wdata
);

   cfg_type    cfg;

   // input register stage
   logic       s1_valid_ff;
   logic       s1_valid_in;
   item_type   s1_item_ff;

   // result register stage
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_result_ff;

   // trip point state
   trip_type   trip_ff;
   trip_type   trip_next;
   result_type result;

   logic       accept;
   logic       advance;

   ttm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ttm_eval u_eval (
      .item      (s1_item_ff),
      .cfg       (cfg),
      .trip      (trip_ff),
      .result    (result),
      .trip_next (trip_next)
   );

   // item moves to the result register when that slot is free or draining
   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      if (accept)
         s1_valid_in = 1'b1;
      else if (advance)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;

      if (advance)
         out_valid_in = 1'b1;
      else if (rsp_bus.ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
         trip_ff.low_point     <= '0;
         trip_ff.low_valid     <= 1'b0;
         trip_ff.high_point    <= '0;
         trip_ff.high_valid    <= 1'b0;
         trip_ff.low_with_hyst <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            trip_ff <= trip_next;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.opcode      <= opcode_type'(req_bus.opcode);
         s1_item_ff.value       <= req_bus.value;
         s1_item_ff.value_valid <= req_bus.value_valid;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.crossed     = out_result_ff.crossed;
   assign rsp_bus.push_value  = out_result_ff.push_value;
   assign rsp_bus.push_enable = out_result_ff.push_enable;
   assign rsp_bus.status      = out_result_ff.status;

endmodule

/* rtl/ttm_cfg.sv */
// ----------------------------------------------------------------------------
// ttm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ttm_cfg import ttm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  temp_type                 csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HYSTERESIS:   cfg_in.hysteresis        = csr_wdata;
            CSR_TEMP_FLOOR:   cfg_in.temp_floor        = csr_wdata;
            CSR_TEMP_CEILING: cfg_in.temp_ceiling      = csr_wdata;
            CSR_LOW_DEFAULT:  cfg_in.low_default       = csr_wdata;
            CSR_POLLING_ON:   cfg_in.polling_on        = csr_wdata[0];
            CSR_CAPABLE:      cfg_in.threshold_capable = csr_wdata[0];
            default:          cfg_in = cfg_ff; // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hysteresis        <= '0;
         cfg_ff.temp_floor        <= '0;
         cfg_ff.temp_ceiling      <= '1;
         cfg_ff.low_default       <= '0;
         cfg_ff.polling_on        <= 1'b0;
         cfg_ff.threshold_capable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/ttm_eval.sv */
// ----------------------------------------------------------------------------
// ttm_eval
// Single-pass evaluation of one item: result and next trip point state.
// ----------------------------------------------------------------------------
module ttm_eval import ttm_pkg::*; (
   input  item_type   item,
   input  cfg_type    cfg,
   input  trip_type   trip,
   output result_type result,
   output trip_type   trip_next
);

   function automatic temp_type clamp_point(temp_type v, temp_type lo, temp_type hi);
      temp_type r;
      if (v > hi)
         r = hi;
      else if (v < lo)
         r = lo;
      else
         r = v;
      return r;
   endfunction

   // lowered point: base - hyst - 1 when hyst + 1 < base, else the floor
   function automatic temp_type lowered_point(temp_type base, temp_type hyst,
                                              temp_type floor_pt);
      logic [TEMP_WIDTH:0] hyst_p1;
      temp_type            r;
      hyst_p1 = {1'b0, hyst} + {{TEMP_WIDTH{1'b0}}, 1'b1};
      if (hyst_p1 < {1'b0, base})
         r = base - hyst - {{(TEMP_WIDTH-1){1'b0}}, 1'b1};
      else
         r = floor_pt;
      return r;
   endfunction

   temp_type clamped;
   temp_type point;
   temp_type lowered;
   logic     lo_hit;
   logic     hi_hit;

   assign clamped = clamp_point(item.value, cfg.temp_floor, cfg.temp_ceiling);
   assign lowered = lowered_point(point, cfg.hysteresis, cfg.temp_floor);
   assign lo_hit  = trip.low_valid && (item.value <= trip.low_with_hyst);
   assign hi_hit  = trip.high_valid && (item.value >= trip.high_point) && item.value_valid;

   // base for the lowered point: the clamped value, or low_default on a clear
   assign point = item.value_valid ? clamped : cfg.low_default;

   always_comb begin
      result.crossed     = 1'b0;
      result.push_value  = '0;
      result.push_enable = 1'b0;
      result.status      = ST_OK;
      trip_next          = trip;

      if (item.opcode == OP_SAMPLE) begin
         result.crossed = lo_hit || hi_hit;
      end else if (!cfg.threshold_capable) begin
         result.status = ST_UNSUPPORTED;
      end else begin
         unique case (item.opcode)
            OP_SET_LOW: begin
               trip_next.low_point     = item.value_valid ? clamped : '0;
               trip_next.low_valid     = item.value_valid;
               trip_next.low_with_hyst = lowered;
               result.push_value       = cfg.polling_on ? point : lowered;
               result.push_enable      = !cfg.polling_on;
            end
            OP_SET_HIGH: begin
               trip_next.high_point = item.value_valid ? clamped : '0;
               trip_next.high_valid = item.value_valid;
               result.push_value    = item.value_valid ? clamped : cfg.temp_ceiling;
               result.push_enable   = !cfg.polling_on;
            end
            default: begin
               result.status = ST_UNKNOWN_SEL;
            end
         endcase
      end
   end

endmodule

/* dv/temp_trip_threshold_monitor_test.sv */
// ----------------------------------------------------------------------------
// temp_trip_threshold_monitor_test
// Self-checking test of the temperature trip threshold monitor. Directed
// items cover the trip compares, clamping, hysteresis fallback, cleared
// points and refused set items. Random phases follow under several register
// settings, with random gaps on both channels and one long response stall.
// Every response transaction is checked against an in-order prediction.
// ----------------------------------------------------------------------------
module temp_trip_threshold_monitor_test;
   import ttm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;     // pipeline is two deep, a little slack
   localparam int HOLD_LENGTH  = 80;    // long response stall, in cycles
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 40;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE_INDEX = 3'd7;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   temp_type                 csr_wdata;

   ttm_req_if req_bus ();
   ttm_rsp_if rsp_bus ();

   temp_trip_threshold_monitor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the block: register values and trip state as the block
   // should hold them after every accepted request transaction.
   cfg_type    cfg_shadow;
   trip_type   trip_state;
   result_type pending_results[$];

   bit send_idle;       // random gaps between request transactions
   bit rsp_idle;        // random stalls before each response transaction
   int hold_cycles;     // nonzero asks the response side for one long stall

   int mismatches;
   int cycle_count;
   int item_count;
   int set_count;
   int crossed_count;
   int setting_count;

   // -------------------------------------------------------------------------
   // Clock and run limit
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------
   function automatic temp_type clamp_temp(temp_type v);
      if (v > cfg_shadow.temp_ceiling)
         return cfg_shadow.temp_ceiling;
      if (v < cfg_shadow.temp_floor)
         return cfg_shadow.temp_floor;
      return v;
   endfunction

   // Lowered point: base - hysteresis - 1. The compare is a signed one on
   // full-width integers, so a base of 0 or 1 never wraps below zero and
   // falls back to the floor.
   function automatic temp_type hyst_point(temp_type base);
      longint b;
      longint h;
      b = base;
      h = cfg_shadow.hysteresis;
      if (h < b - 1)
         return temp_type'(b - h - 1);
      return cfg_shadow.temp_floor;
   endfunction

   // Response to one request transaction; advances the trip state.
   function automatic result_type trip_response(item_type it);
      result_type r;
      temp_type   pt;
      r = '0;
      r.status = ST_OK;
      item_count++;
      if (it.opcode == OP_SAMPLE) begin
         // low compare ignores value_valid, high compare needs it
         r.crossed = (trip_state.low_valid && it.value <= trip_state.low_with_hyst) ||
                     (trip_state.high_valid && it.value >= trip_state.high_point &&
                      it.value_valid);
      end else if (!cfg_shadow.threshold_capable) begin
         r.status = ST_UNSUPPORTED;
      end else if (it.opcode == OP_INVALID) begin
         r.status = ST_UNKNOWN_SEL;
      end else if (it.opcode == OP_SET_LOW) begin
         set_count++;
         if (it.value_valid) begin
            pt = clamp_temp(it.value);
            trip_state.low_point = pt;
            trip_state.low_valid = 1'b1;
         end else begin
            // cleared low point: report and lower from the default
            pt = cfg_shadow.low_default;
            trip_state.low_point = '0;
            trip_state.low_valid = 1'b0;
         end
         trip_state.low_with_hyst = hyst_point(trip_state.low_valid ?
                                               trip_state.low_point :
                                               cfg_shadow.low_default);
         r.push_value  = cfg_shadow.polling_on ? pt : trip_state.low_with_hyst;
         r.push_enable = !cfg_shadow.polling_on;
      end else begin
         set_count++;
         if (it.value_valid) begin
            pt = clamp_temp(it.value);
            trip_state.high_point = pt;
            trip_state.high_valid = 1'b1;
         end else begin
            // cleared high point reports the ceiling
            pt = cfg_shadow.temp_ceiling;
            trip_state.high_point = '0;
            trip_state.high_valid = 1'b0;
         end
         r.push_value  = pt;
         r.push_enable = !cfg_shadow.polling_on;
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Response side: random stalls per transaction, plus a long hold when
   // asked. The hold is counted here so the request side keeps pushing.
   // -------------------------------------------------------------------------
   initial begin : rsp_ready_drive
      int stall;
      int hold;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            hold = hold_cycles;
            hold_cycles <= 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         stall = rsp_idle ? $urandom_range(0, 11) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         // ready is high from here on; a transaction is any edge with valid
         while (!rsp_bus.valid && hold_cycles == 0) @(posedge clock);
      end
   end

   function automatic void log_error(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // Each response transaction against the oldest prediction.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            log_error($sformatf({"response with nothing pending: ",
                                 "crossed=%0b push=%h en=%0b st=%0d"},
                                rsp_bus.crossed, rsp_bus.push_value,
                                rsp_bus.push_enable, rsp_bus.status));
         end else begin
            want = pending_results.pop_front();
            if (want.crossed)
               crossed_count++;
            if (rsp_bus.crossed !== want.crossed ||
                rsp_bus.push_value !== want.push_value ||
                rsp_bus.push_enable !== want.push_enable ||
                rsp_bus.status !== want.status) begin
               log_error($sformatf({"expected crossed=%0b push=%h en=%0b st=%0d, ",
                                    "got crossed=%0b push=%h en=%0b st=%0d"},
                                   want.crossed, want.push_value, want.push_enable,
                                   want.status, rsp_bus.crossed, rsp_bus.push_value,
                                   rsp_bus.push_enable, rsp_bus.status));
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request side and register port
   // -------------------------------------------------------------------------
   function automatic item_type make_item(opcode_type op, temp_type v, logic vv);
      item_type it;
      it.opcode      = op;
      it.value       = v;
      it.value_valid = vv;
      return it;
   endfunction

   // One request transaction; the prediction is queued at the accepting edge.
   task automatic send_item(item_type it);
      int gap;
      gap = send_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= it.opcode;
      req_bus.value       <= it.value;
      req_bus.value_valid <= it.value_valid;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(trip_response(it));
   endtask

   // Stop offering and wait until every response has come back.
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_WIDTH-1:0] idx, temp_type data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_HYSTERESIS:   cfg_shadow.hysteresis        = data;
         CSR_TEMP_FLOOR:   cfg_shadow.temp_floor        = data;
         CSR_TEMP_CEILING: cfg_shadow.temp_ceiling      = data;
         CSR_LOW_DEFAULT:  cfg_shadow.low_default       = data;
         CSR_POLLING_ON:   cfg_shadow.polling_on        = data[0];
         CSR_CAPABLE:      cfg_shadow.threshold_capable = data[0];
         default: ;        // unused index, no effect
      endcase
   endtask

   // Only called with the block idle.
   task automatic load_config(cfg_type c);
      write_reg(CSR_HYSTERESIS, c.hysteresis);
      write_reg(CSR_TEMP_FLOOR, c.temp_floor);
      write_reg(CSR_TEMP_CEILING, c.temp_ceiling);
      write_reg(CSR_LOW_DEFAULT, c.low_default);
      write_reg(CSR_POLLING_ON, temp_type'(c.polling_on));
      write_reg(CSR_CAPABLE, temp_type'(c.threshold_capable));
      csr_wr_en <= 1'b0;
      setting_count++;
   endtask

   function automatic cfg_type random_cfg();
      cfg_type  c;
      temp_type swap;
      c.hysteresis = ($urandom_range(0, 3) == 0) ? temp_type'($urandom) :
                                                   temp_type'($urandom_range(0, 300));
      c.temp_floor   = temp_type'($urandom_range(0, 20000));
      c.temp_ceiling = temp_type'($urandom_range(30000, 65535));
      if ($urandom_range(0, 4) == 0) begin
         // floor above ceiling
         swap           = c.temp_floor;
         c.temp_floor   = c.temp_ceiling;
         c.temp_ceiling = swap;
      end
      c.low_default       = temp_type'($urandom);
      c.polling_on        = 1'($urandom_range(0, 1));
      c.threshold_capable = ($urandom_range(0, 5) != 0);
      return c;
   endfunction

   // Random item, biased so values land on and around the live thresholds.
   function automatic item_type random_item();
      item_type it;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         it.opcode = OP_SAMPLE;
      else if (pick < 70)
         it.opcode = OP_SET_LOW;
      else if (pick < 90)
         it.opcode = OP_SET_HIGH;
      else
         it.opcode = OP_INVALID;
      it.value_valid = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: it.value = temp_type'($urandom);
         4, 5:       it.value = temp_type'(trip_state.low_with_hyst +
                                           $urandom_range(0, 4) - 2);
         6, 7:       it.value = temp_type'(trip_state.high_point +
                                           $urandom_range(0, 4) - 2);
         8:          it.value = $urandom_range(0, 1) ? '1 : '0;
         default: begin
            // clamp edges and the hysteresis fallback boundary
            case ($urandom_range(0, 2))
               0:       it.value = temp_type'(cfg_shadow.temp_floor + $urandom_range(0, 2) - 1);
               1:       it.value = temp_type'(cfg_shadow.temp_ceiling + $urandom_range(0, 2) - 1);
               default: it.value = temp_type'(cfg_shadow.hysteresis + $urandom_range(0, 3));
            endcase
         end
      endcase
      return it;
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset values: no trip point valid, unknown selector, cleared points.
   task automatic test_reset_defaults();
      send_item(make_item(OP_SAMPLE, '0, 1'b1));
      send_item(make_item(OP_SAMPLE, '1, 1'b1));
      send_item(make_item(OP_INVALID, 16'h1234, 1'b1));
      send_item(make_item(OP_SET_HIGH, 16'h4321, 1'b0));
      send_item(make_item(OP_SET_LOW, 16'h0042, 1'b0));
      drain_block();
   endtask

   // Both compares, the sample-valid gating of the high compare and
   // clamping of a low point below the floor.
   task automatic test_trip_points();
      cfg_type c;
      c.hysteresis        = 16'd5;
      c.temp_floor        = 16'd10;
      c.temp_ceiling      = 16'd1000;
      c.low_default       = 16'd50;
      c.polling_on        = 1'b0;
      c.threshold_capable = 1'b1;
      load_config(c);
      send_item(make_item(OP_SET_LOW, 16'd100, 1'b1));
      send_item(make_item(OP_SET_HIGH, 16'd900, 1'b1));
      send_item(make_item(OP_SAMPLE, 16'd94, 1'b1));
      send_item(make_item(OP_SAMPLE, 16'd95, 1'b1));
      send_item(make_item(OP_SAMPLE, 16'd900, 1'b1));
      send_item(make_item(OP_SAMPLE, 16'd900, 1'b0));
      send_item(make_item(OP_SAMPLE, 16'd0, 1'b0));
      send_item(make_item(OP_SET_LOW, 16'd6, 1'b1));
      drain_block();
   endtask

   // Floor above ceiling, polling on, huge hysteresis, then the boundary
   // where hysteresis meets low - 1.
   task automatic test_clamping_and_hysteresis();
      cfg_type c;
      c.hysteresis        = '1;
      c.temp_floor        = 16'd500;
      c.temp_ceiling      = 16'd100;
      c.low_default       = '1;
      c.polling_on        = 1'b1;
      c.threshold_capable = 1'b1;
      load_config(c);
      send_item(make_item(OP_SET_LOW, 16'd600, 1'b1));
      send_item(make_item(OP_SET_HIGH, 16'd50, 1'b1));
      send_item(make_item(OP_SET_HIGH, 16'd300, 1'b1));
      send_item(make_item(OP_SET_LOW, 16'd0, 1'b0));
      send_item(make_item(OP_SAMPLE, '1, 1'b1));
      drain_block();

      c.hysteresis   = 16'd6;
      c.temp_floor   = '0;
      c.temp_ceiling = '1;
      c.low_default  = '0;
      c.polling_on   = 1'b0;
      load_config(c);
      send_item(make_item(OP_SET_LOW, 16'd7, 1'b1));
      send_item(make_item(OP_SET_LOW, 16'd8, 1'b1));
      send_item(make_item(OP_SET_LOW, '1, 1'b0));
      send_item(make_item(OP_SET_HIGH, '1, 1'b1));
      drain_block();
   endtask

   // Capability clear refuses every set and selector; samples still work.
   // An unused register index is written too and must change nothing.
   task automatic test_capability_clear();
      cfg_type c;
      c = cfg_shadow;
      c.threshold_capable = 1'b0;
      write_reg(CSR_SPARE_INDEX, '1);
      load_config(c);
      send_item(make_item(OP_SET_LOW, 16'd300, 1'b1));
      send_item(make_item(OP_SET_HIGH, 16'd300, 1'b0));
      send_item(make_item(OP_INVALID, '1, 1'b1));
      send_item(make_item(OP_SAMPLE, '1, 1'b1));
      drain_block();
   endtask

   // Random phases under changing registers; the first two use the
   // extremes, one phase runs with no idling on either side.
   task automatic test_random_phases();
      cfg_type c;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         c = random_cfg();
         if (p == 0) begin
            c.hysteresis   = '1;
            c.temp_floor   = '1;
            c.temp_ceiling = '1;
            c.low_default  = '1;
            c.polling_on   = 1'b1;
            c.threshold_capable = 1'b1;
         end else if (p == 1) begin
            c.hysteresis   = '0;
            c.temp_floor   = '0;
            c.temp_ceiling = '0;
            c.low_default  = '0;
            c.polling_on   = 1'b0;
            c.threshold_capable = 1'b1;
         end
         send_idle = (p != 3);
         rsp_idle  = (p != 3);
         load_config(c);
         repeat (PHASE_ITEMS) send_item(random_item());
         drain_block();
      end
      send_idle = 1'b1;
      rsp_idle  = 1'b1;
   endtask

   // Long response stall while requests keep coming back to back, so the
   // pipeline fills and the request side backs up. Then the sender pauses
   // until everything is back, and streams once more.
   task automatic test_backpressure();
      cfg_type c;
      c = random_cfg();
      c.threshold_capable = 1'b1;
      load_config(c);
      send_idle = 1'b0;
      hold_cycles <= HOLD_LENGTH;
      repeat (30) send_item(random_item());
      drain_block();
      repeat (20) send_item(random_item());
      send_idle = 1'b1;
      drain_block();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= CSR_HYSTERESIS;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_SAMPLE;
      req_bus.value       <= '0;
      req_bus.value_valid <= 1'b0;
      hold_cycles         = 0;
      send_idle           = 1'b1;
      rsp_idle            = 1'b1;

      cfg_shadow.hysteresis        = '0;
      cfg_shadow.temp_floor        = '0;
      cfg_shadow.temp_ceiling      = '1;
      cfg_shadow.low_default       = '0;
      cfg_shadow.polling_on        = 1'b0;
      cfg_shadow.threshold_capable = 1'b1;
      trip_state                   = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_trip_points();
      test_clamping_and_hysteresis();
      test_capability_clear();
      test_random_phases();
      test_backpressure();

      drain_block();
      repeat (10) @(posedge clock);

      $display("Checked %0d transactions: %0d set items, %0d crossings, %0d register settings",
               item_count, set_count, crossed_count, setting_count);
      $display("Mismatches: %0d in %0d cycles", mismatches, cycle_count);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
